FILE: hw/rtl/lrukv_pkg.sv
`default_nettype none

package lrukv_pkg;

    // Command codes carried by a request.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Capacity register.
    localparam int unsigned CAP_WIDTH = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/lrukv_if.sv
`default_nettype none

// Request channel: one get or put.
interface lrukv_req_if #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [KEY_WIDTH-1:0]   lookup_key;
    logic [VALUE_WIDTH-1:0] write_value;

    modport source (output valid, output cmd, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input cmd, input lookup_key, input write_value,
                    output ready);
endinterface

// Response channel: one result per request.
interface lrukv_rsp_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [VALUE_WIDTH-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lrukv_kv_mem.sv
`default_nettype none

// Key and value storage: one write port, one registered read port.
module lrukv_kv_mem
    import lrukv_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [KEY_WIDTH-1:0]     i_wr_key,
    input  wire logic [VALUE_WIDTH-1:0]   i_wr_value,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [KEY_WIDTH-1:0]     o_rd_key,
    output logic      [VALUE_WIDTH-1:0]   o_rd_value
);

    logic [KEY_WIDTH-1:0]   r_keys   [DEPTH];
    logic [VALUE_WIDTH-1:0] r_values [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_keys[i_wr_addr]   <= i_wr_key;
            r_values[i_wr_addr] <= i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key   <= r_keys[i_rd_addr];
            o_rd_value <= r_values[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_key_value_cache_unit.sv
// Fully associative key-value cache with least-recently-used replacement.
// Requests arrive on i_req (valid/ready): cmd selects a get or a put, with a
// key and, for a put, a value. Each request yields exactly one response on
// o_rsp: found tells whether the key was held before the request, and
// read_value carries the stored value on a get hit and zero otherwise.
// The capacity register is written through i_cfg_wr_en/i_cfg_wr_data; the
// user must do so only while the block is idle, which the block does not
// enforce. Values outside 1..ENTRIES are clamped. After acceptance a request
// passes a scan (one memory read per entry over a single key comparator), a
// drain of the last read, an update of ranks and storage, and the load of the
// response register. i_req.ready is high only while idle, so a new request is
// not accepted until the previous one has finished its last step.
// The response register lets a new request be accepted while the previous
// response still waits; if the receiver stalls, the finished request holds
// in its last step until the register frees up.
// Reset clears all valid bits, ranks and the entry count and sets the
// capacity to 16; the key and value memories are not cleared.
`default_nettype none

module lru_key_value_cache_unit
    import lrukv_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CAP_WIDTH-1:0] i_cfg_wr_data,
    lrukv_req_if.sink                 i_req,
    lrukv_rsp_if.source               o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Control state.
    t_state r_state, n_state;
    logic [CAP_WIDTH-1:0] r_capacity;
    logic [ENTRIES-1:0]   r_valid;
    logic [IDX_W-1:0]     r_rank [ENTRIES];
    logic [CNT_W-1:0]     r_count;

    // Scan bookkeeping.
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_live;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_slot;
    logic [IDX_W-1:0] r_hit_rank;
    logic [VALUE_WIDTH-1:0] r_hit_value;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_slot;
    logic [IDX_W-1:0] r_victim_slot;

    // Captured request (payload, no reset).
    logic                   r_cmd;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;

    // Response register.
    logic                   r_out_valid;
    logic                   r_out_found;
    logic [VALUE_WIDTH-1:0] r_out_value;

    // Sequencer outputs.
    logic w_in_ready;
    logic w_rd_en;
    logic w_mem_we;
    logic w_load_out;

    logic                   w_accept;
    logic [KEY_WIDTH-1:0]   w_rd_key;
    logic [VALUE_WIDTH-1:0] w_rd_value;
    logic [CNT_W-1:0]       w_cap_eff;
    logic                   w_evict;
    logic [IDX_W-1:0]       w_target;
    logic [IDX_W-1:0]       w_oldest_rank;
    logic                   w_last_addr;

    assign w_accept    = i_req.valid && w_in_ready;
    assign w_last_addr = (r_addr == IDX_W'(ENTRIES - 1));

    // The capacity register is clamped into 1..ENTRIES.
    always_comb begin
        if (r_capacity == '0) begin
            w_cap_eff = CNT_W'(1);
        end else if (32'(r_capacity) > ENTRIES) begin
            w_cap_eff = CNT_W'(ENTRIES);
        end else begin
            w_cap_eff = CNT_W'(r_capacity);
        end
    end

    // Ranks of valid entries are exactly 0..count-1, so the least recent
    // entry is the one ranked count-1.
    assign w_oldest_rank = IDX_W'(r_count - CNT_W'(1));
    assign w_evict       = (r_count >= w_cap_eff);
    assign w_target      = r_hit ? r_hit_slot : (w_evict ? r_victim_slot : r_free_slot);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_last_addr) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_mem_we   = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_SCAN: begin
                w_rd_en = 1'b1;
            end
            ST_UPDATE: begin
                w_mem_we = (r_cmd == CMD_PUT);
            end
            ST_FINISH: begin
                w_load_out = !r_out_valid || o_rsp.ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_req.cmd;
            r_key   <= i_req.lookup_key;
            r_value <= i_req.write_value;
        end
    end

    // Scan address and read tracking. The comparison runs in the cycle after
    // its address because the memory read is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= w_rd_en;
            if (w_accept) begin
                r_addr <= '0;
            end else if (w_rd_en && !w_last_addr) begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_idx <= r_addr;
        end
    end

    // Per-entry checks on the entry just read: key match, first free slot,
    // and least recent entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (w_accept) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_rd_live) begin
            if (r_valid[r_rd_idx] && (w_rd_key == r_key) && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!r_valid[r_rd_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_live) begin
            if (r_valid[r_rd_idx] && (w_rd_key == r_key) && !r_hit) begin
                r_hit_slot  <= r_rd_idx;
                r_hit_rank  <= r_rank[r_rd_idx];
                r_hit_value <= w_rd_value;
            end
            if (!r_valid[r_rd_idx] && !r_free_found) begin
                r_free_slot <= r_rd_idx;
            end
            if (r_valid[r_rd_idx] && (r_rank[r_rd_idx] == w_oldest_rank)) begin
                r_victim_slot <= r_rd_idx;
            end
        end
    end

    // Rank, valid and count update. All ranks that change are updated in parallel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (r_state == ST_UPDATE) begin
            if (r_hit) begin
                // Promote the hit entry; more recent entries age by one.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_hit_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
            end else if (r_cmd == CMD_PUT) begin
                // Insert as most recent, reusing the least recent slot when full.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == w_target) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= '0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                if (!w_evict) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_found <= r_hit;
            r_out_value <= (r_hit && (r_cmd == CMD_GET)) ? r_hit_value : '0;
        end
    end

    lrukv_kv_mem #(
        .DEPTH       (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_kv_mem (
        .i_clk      (i_clk),
        .i_wr_en    (w_mem_we),
        .i_wr_addr  (w_target),
        .i_wr_key   (r_key),
        .i_wr_value (r_value),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (r_addr),
        .o_rd_key   (w_rd_key),
        .o_rd_value (w_rd_value)
    );

    assign i_req.ready      = w_in_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.read_value = r_out_value;

endmodule

`default_nettype wire
